FILE: hdl/alu_instruction_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// alu instruction encoder assertion macros
// concurrent assertion helpers clocked on the block clock
// ----------------------------------------------------------------------------
`ifndef ALU_INSTRUCTION_ENCODER_CORE_DEFINES_SVH
`define ALU_INSTRUCTION_ENCODER_CORE_DEFINES_SVH

// checked only outside reset
`define AIE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define AIE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/aie_pkg.sv
// ----------------------------------------------------------------------------
// aie_pkg
// shared types, codes and lookup tables of the alu instruction encoder
// ----------------------------------------------------------------------------
`default_nettype none

package aie_pkg;

   // instruction forms
   localparam logic FORM_REG = 1'b0;
   localparam logic FORM_IMM = 1'b1;

   // register descriptor kinds
   localparam logic [1:0] KIND_UNSIGNED = 2'd1;
   localparam logic [1:0] KIND_FLOAT    = 2'd2;

   // operation indexes
   localparam logic [4:0] ALU_OR      = 5'd0;
   localparam logic [4:0] ALU_AND     = 5'd1;
   localparam logic [4:0] ALU_NEG     = 5'd2;
   localparam logic [4:0] ALU_XOR     = 5'd3;
   localparam logic [4:0] ALU_NOT     = 5'd4;
   localparam logic [4:0] ALU_ADD     = 5'd5;
   localparam logic [4:0] ALU_SUB     = 5'd6;
   localparam logic [4:0] ALU_MUL     = 5'd7;
   localparam logic [4:0] ALU_DIV     = 5'd8;
   localparam logic [4:0] ALU_SHR     = 5'd9;
   localparam logic [4:0] ALU_SHL     = 5'd10;
   localparam logic [4:0] ALU_CLZ     = 5'd11;
   localparam logic [4:0] ALU_EQ      = 5'd12;
   localparam logic [4:0] ALU_NE      = 5'd13;
   localparam logic [4:0] ALU_GT      = 5'd14;
   localparam logic [4:0] ALU_GE      = 5'd15;
   localparam logic [4:0] ALU_LT      = 5'd16;
   localparam logic [4:0] ALU_LE      = 5'd17;
   localparam logic [4:0] ALU_FTOI    = 5'd18;
   localparam logic [4:0] ALU_ITOF    = 5'd19;
   localparam logic [4:0] ALU_FLOOR   = 5'd20;
   localparam logic [4:0] ALU_FRAC    = 5'd21;
   localparam logic [4:0] ALU_RECIP   = 5'd22;
   localparam logic [4:0] ALU_ABS     = 5'd23;
   localparam logic [4:0] ALU_SQRT    = 5'd24;
   localparam logic [4:0] ALU_SHUFFLE = 5'd25;
   localparam logic [4:0] ALU_COPY    = 5'd26;
   localparam logic [4:0] ALU_CTZ     = 5'd27;

   // fixed opcodes and remaps
   localparam logic [5:0] OPC_FTOI       = 6'd48;
   localparam logic [5:0] OPC_ITOF       = 6'd42;
   localparam logic [5:0] OPC_SHR_U      = 6'd10;
   localparam logic [5:0] OPC_CMP_S_LO   = 6'h12;
   localparam logic [5:0] OPC_CMP_S_HI   = 6'h15;
   localparam logic [5:0] OPC_CMP_U_OFFS = 6'd4;

   localparam logic [2:0] INSTR_CLASS_REG = 3'd6;

   localparam logic signed [16:0] IMM_MASKED_MAX   = 17'sd255;
   localparam logic signed [16:0] IMM_UNMASKED_MAX = 17'sd8191;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_TYPES        = 3'd1,
      ERR_NO_OPCODE    = 3'd2,
      ERR_SCALAR_DEST  = 3'd3,
      ERR_INT_DEST     = 3'd4,
      ERR_VEC_MISMATCH = 3'd5,
      ERR_FLT_MISMATCH = 3'd6,
      ERR_IMM_RANGE    = 3'd7
   } err_type;

   typedef struct packed {
      logic                operation;
      logic [4:0]          alu_op;
      logic [7:0]          dest_reg;
      logic                src1_present;
      logic [7:0]          src1_reg;
      logic [7:0]          src2_reg;
      logic                mask_enable;
      logic                mask_invert;
      logic [4:0]          mask_reg;
      logic signed [16:0]  immediate;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] code;
   } fmt_entry_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] code;
   } opc_entry_type;

   // decode stage to check stage
   typedef struct packed {
      logic               form;
      logic               is_cmp;
      logic               is_conv;
      logic               is_shr;
      logic               s1;
      err_type            err;
      logic [5:0]         opc;
      logic [2:0]         fmt;
      logic [4:0]         d_idx;
      logic               d_vec;
      logic               d_flt;
      logic [4:0]         a_idx;
      logic               a_vec;
      logic               a_flt;
      logic               a_uns;
      logic [4:0]         b_idx;
      logic               b_vec;
      logic               men;
      logic [4:0]         mreg;
      logic signed [16:0] imm;
   } dec_type;

   // check stage to pack stage
   typedef struct packed {
      logic               form;
      err_type            err;
      logic [5:0]         opc;
      logic [2:0]         fmt;
      logic [4:0]         d_idx;
      logic [4:0]         a_idx;
      logic [4:0]         b_idx;
      logic               men;
      logic [4:0]         mreg;
      logic signed [16:0] imm;
   } chk_type;

   // register form format, index {vec1, vec2, mask enable, mask invert}
   function automatic fmt_entry_type fmt_reg_lookup(input logic [3:0] idx);
      fmt_entry_type e;
      e = '0;
      unique case (idx)
         4'd0:  e = '{hit: 1'b1, code: 3'd0};
         4'd8:  e = '{hit: 1'b1, code: 3'd1};
         4'd10: e = '{hit: 1'b1, code: 3'd2};
         4'd11: e = '{hit: 1'b1, code: 3'd3};
         4'd12: e = '{hit: 1'b1, code: 3'd4};
         4'd14: e = '{hit: 1'b1, code: 3'd5};
         4'd15: e = '{hit: 1'b1, code: 3'd6};
         default: e = '0;
      endcase
      return e;
   endfunction

   // immediate form format, index {dest vec, src vec, mask enable, mask invert}
   function automatic fmt_entry_type fmt_imm_lookup(input logic [3:0] idx);
      fmt_entry_type e;
      e = '0;
      unique case (idx)
         4'd0:  e = '{hit: 1'b1, code: 3'd0};
         4'd4:  e = '{hit: 1'b1, code: 3'd1};
         4'd8:  e = '{hit: 1'b1, code: 3'd4};
         4'd10: e = '{hit: 1'b1, code: 3'd5};
         4'd11: e = '{hit: 1'b1, code: 3'd6};
         4'd12: e = '{hit: 1'b1, code: 3'd1};
         4'd14: e = '{hit: 1'b1, code: 3'd2};
         4'd15: e = '{hit: 1'b1, code: 3'd3};
         default: e = '0;
      endcase
      return e;
   endfunction

   // col: bit 1 float, bit 0 binary
   function automatic opc_entry_type opc_lookup(input logic [4:0] op, input logic [1:0] col);
      logic [3:0] hit;
      logic [5:0] row [4];
      opc_entry_type e;
      hit = 4'b0000;
      row = '{default: 6'd0};
      unique case (op)
         ALU_OR:      begin hit = 4'b0010; row[1] = 6'd0; end
         ALU_AND:     begin hit = 4'b0010; row[1] = 6'd1; end
         ALU_NEG:     begin hit = 4'b0001; row[0] = 6'd2; end
         ALU_XOR:     begin hit = 4'b0010; row[1] = 6'd3; end
         ALU_NOT:     begin hit = 4'b0001; row[0] = 6'd4; end
         ALU_ADD:     begin hit = 4'b1010; row[1] = 6'd5; row[3] = 6'd32; end
         ALU_SUB:     begin hit = 4'b1010; row[1] = 6'd6; row[3] = 6'd33; end
         ALU_MUL:     begin hit = 4'b1010; row[1] = 6'd7; row[3] = 6'd34; end
         ALU_DIV:     begin hit = 4'b1010; row[1] = 6'd8; row[3] = 6'd35; end
         ALU_SHR:     begin hit = 4'b0010; row[1] = 6'd9; end
         ALU_SHL:     begin hit = 4'b0010; row[1] = 6'd11; end
         ALU_CLZ:     begin hit = 4'b0001; row[0] = 6'd12; end
         ALU_EQ:      begin hit = 4'b1010; row[1] = 6'd16; row[3] = 6'd13; end
         ALU_NE:      begin hit = 4'b1010; row[1] = 6'd17; row[3] = 6'd14; end
         ALU_GT:      begin hit = 4'b1010; row[1] = 6'd18; row[3] = 6'd44; end
         ALU_GE:      begin hit = 4'b1010; row[1] = 6'd19; row[3] = 6'd45; end
         ALU_LT:      begin hit = 4'b1010; row[1] = 6'd20; row[3] = 6'd46; end
         ALU_LE:      begin hit = 4'b1010; row[1] = 6'd21; row[3] = 6'd47; end
         ALU_FLOOR:   begin hit = 4'b0100; row[2] = 6'd38; end
         ALU_FRAC:    begin hit = 4'b0100; row[2] = 6'd39; end
         ALU_RECIP:   begin hit = 4'b0100; row[2] = 6'd40; end
         ALU_ABS:     begin hit = 4'b0100; row[2] = 6'd41; end
         ALU_SQRT:    begin hit = 4'b0100; row[2] = 6'd46; end
         ALU_SHUFFLE: begin hit = 4'b1010; row[1] = 6'd13; row[3] = 6'd13; end
         ALU_COPY:    begin hit = 4'b1111; row = '{default: 6'd15}; end
         ALU_CTZ:     begin hit = 4'b0001; row[0] = 6'd14; end
         default:     begin hit = 4'b0000; end
      endcase
      e.hit  = hit[col];
      e.code = row[col];
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/aie_decode.sv
// ----------------------------------------------------------------------------
// aie_decode
// first stage: descriptor decode, format and opcode lookup, type checks
// ----------------------------------------------------------------------------
`default_nettype none

module aie_decode import aie_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire req_type in_data,
   output logic         in_stall,
   output logic         out_valid,
   output dec_type      out_data,
   input  wire logic    out_stall
);

   logic          advance;
   logic          valid_ff;
   dec_type       data_ff;
   dec_type       data_in;
   logic [7:0]    src1;
   logic          b_flt;
   fmt_entry_type fmt_reg;
   fmt_entry_type fmt_imm;
   opc_entry_type opc_reg;
   opc_entry_type opc_imm;

   always_comb begin
      src1 = in_data.src1_present ? in_data.src1_reg : 8'd0;
      b_flt = in_data.src2_reg[7:6] == KIND_FLOAT;

      data_in = '0;
      data_in.form    = in_data.operation;
      data_in.is_cmp  = (in_data.alu_op >= ALU_EQ) && (in_data.alu_op <= ALU_LE);
      data_in.is_conv = (in_data.alu_op == ALU_FTOI) || (in_data.alu_op == ALU_ITOF);
      data_in.is_shr  = in_data.alu_op == ALU_SHR;
      data_in.s1      = in_data.src1_present;
      data_in.d_idx   = in_data.dest_reg[4:0];
      data_in.d_vec   = in_data.dest_reg[5];
      data_in.d_flt   = in_data.dest_reg[7:6] == KIND_FLOAT;
      data_in.a_idx   = src1[4:0];
      data_in.a_vec   = src1[5];
      data_in.a_flt   = in_data.src1_present && (src1[7:6] == KIND_FLOAT);
      data_in.a_uns   = in_data.src1_present && (src1[7:6] == KIND_UNSIGNED);
      data_in.b_idx   = in_data.src2_reg[4:0];
      data_in.b_vec   = in_data.src2_reg[5];
      data_in.men     = in_data.mask_enable;
      data_in.mreg    = in_data.mask_reg;
      data_in.imm     = in_data.immediate;
      data_in.err     = ERR_NONE;

      fmt_reg = fmt_reg_lookup({in_data.src1_present ? data_in.a_vec : data_in.d_vec,
                                data_in.b_vec, in_data.mask_enable, in_data.mask_invert});
      fmt_imm = fmt_imm_lookup({data_in.d_vec, data_in.a_vec,
                                in_data.mask_enable, in_data.mask_invert});
      opc_reg = opc_lookup(in_data.alu_op, {b_flt, in_data.src1_present});
      opc_imm = opc_lookup(in_data.alu_op, {1'b0, in_data.src1_present});

      if (in_data.operation == FORM_REG) begin
         data_in.fmt = fmt_reg.code;
         if (!fmt_reg.hit) begin
            data_in.err = ERR_TYPES;
         end else if (in_data.alu_op == ALU_FTOI) begin
            data_in.opc = OPC_FTOI;
            if (!in_data.src1_present || !data_in.a_flt || !b_flt) data_in.err = ERR_TYPES;
         end else if (in_data.alu_op == ALU_ITOF) begin
            data_in.opc = OPC_ITOF;
            if (!in_data.src1_present || data_in.a_flt || !b_flt) data_in.err = ERR_TYPES;
         end else if ((b_flt && in_data.src1_present && !data_in.a_flt) ||
                      (!b_flt && data_in.a_flt)) begin
            // mixed int and float sources
            data_in.err = ERR_TYPES;
         end else if (!opc_reg.hit) begin
            data_in.err = ERR_NO_OPCODE;
         end else begin
            data_in.opc = opc_reg.code;
         end
      end else begin
         data_in.fmt = fmt_imm.code;
         if (!data_in.d_vec && in_data.src1_present && data_in.a_vec && !data_in.is_cmp) begin
            data_in.err = ERR_TYPES;
         end else if (!fmt_imm.hit) begin
            data_in.err = ERR_TYPES;
         end else if ((data_in.d_flt || data_in.a_flt) &&
                      ((in_data.alu_op != ALU_OR) || (in_data.immediate != 17'sd0))) begin
            data_in.err = ERR_TYPES;
         end else if (!opc_imm.hit) begin
            data_in.err = ERR_NO_OPCODE;
         end else begin
            data_in.opc = opc_imm.code;
         end
      end
   end

   assign advance   = !valid_ff || !out_stall;
   assign in_stall  = !advance;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/aie_check.sv
// ----------------------------------------------------------------------------
// aie_check
// second stage: unsigned opcode remaps, destination and type agreement checks
// ----------------------------------------------------------------------------
`default_nettype none

module aie_check import aie_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire dec_type in_data,
   output logic         in_stall,
   output logic         out_valid,
   output chk_type      out_data,
   input  wire logic    out_stall
);

   logic    advance;
   logic    valid_ff;
   chk_type data_ff;
   chk_type data_in;

   always_comb begin
      data_in.form  = in_data.form;
      data_in.fmt   = in_data.fmt;
      data_in.d_idx = in_data.d_idx;
      data_in.a_idx = in_data.a_idx;
      data_in.b_idx = in_data.b_idx;
      data_in.men   = in_data.men;
      data_in.mreg  = in_data.mreg;
      data_in.imm   = in_data.imm;
      data_in.err   = in_data.err;
      data_in.opc   = (in_data.is_shr && in_data.a_uns) ? OPC_SHR_U : in_data.opc;

      if (in_data.err == ERR_NONE) begin
         if (in_data.is_cmp) begin
            if (in_data.d_vec) begin
               data_in.err = ERR_SCALAR_DEST;
            end else if (in_data.d_flt) begin
               data_in.err = ERR_INT_DEST;
            end else if (in_data.a_uns && (data_in.opc >= OPC_CMP_S_LO) &&
                         (data_in.opc <= OPC_CMP_S_HI)) begin
               data_in.opc = data_in.opc + OPC_CMP_U_OFFS;
            end
         end else if ((in_data.form == FORM_REG) && in_data.s1 &&
                      (in_data.d_vec != (in_data.a_vec | in_data.b_vec))) begin
            data_in.err = ERR_VEC_MISMATCH;
         end else if (in_data.s1 && (in_data.a_flt != (in_data.d_flt != in_data.is_conv))) begin
            // conversions flip the expected source kind
            data_in.err = ERR_FLT_MISMATCH;
         end
      end
   end

   assign advance   = !valid_ff || !out_stall;
   assign in_stall  = !advance;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/aie_pack.sv
// ----------------------------------------------------------------------------
// aie_pack
// last stage: immediate range check and instruction word assembly
// ----------------------------------------------------------------------------
`default_nettype none

module aie_pack import aie_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire chk_type in_data,
   output logic         in_stall,
   output logic         out_valid,
   output logic [31:0]  out_instruction,
   output err_type      out_error,
   input  wire logic    out_stall
);

   logic        advance;
   logic        valid_ff;
   logic [31:0] instr_ff;
   logic [31:0] instr_in;
   err_type     err_ff;
   err_type     err_in;
   logic [31:0] word;
   logic        imm_ok;

   always_comb begin
      if (in_data.form == FORM_REG) begin
         word = {INSTR_CLASS_REG, in_data.opc, in_data.fmt, in_data.b_idx,
                 in_data.mreg, in_data.d_idx, in_data.a_idx};
         imm_ok = 1'b1;
      end else if (in_data.men) begin
         word = {in_data.opc, in_data.fmt, in_data.imm[7:0], in_data.mreg,
                 in_data.d_idx, in_data.a_idx};
         imm_ok = (in_data.imm >= -IMM_MASKED_MAX) && (in_data.imm <= IMM_MASKED_MAX);
      end else begin
         word = {in_data.opc, in_data.fmt, in_data.imm[12:0], in_data.d_idx, in_data.a_idx};
         imm_ok = (in_data.imm >= -IMM_UNMASKED_MAX) && (in_data.imm <= IMM_UNMASKED_MAX);
      end

      if (in_data.err != ERR_NONE) begin
         err_in = in_data.err;
      end else if (!imm_ok) begin
         err_in = ERR_IMM_RANGE;
      end else begin
         err_in = ERR_NONE;
      end
      instr_in = (err_in == ERR_NONE) ? word : 32'd0;
   end

   assign advance         = !valid_ff || !out_stall;
   assign in_stall        = !advance;
   assign out_valid       = valid_ff;
   assign out_instruction = instr_ff;
   assign out_error       = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         instr_ff <= instr_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/alu_instruction_encoder_core.sv
// ----------------------------------------------------------------------------
// alu_instruction_encoder_core
// encodes arithmetic instruction requests into 32-bit instruction words
// ----------------------------------------------------------------------------
// usage
//   req_* carries one instruction request per transaction, taken at a rising
//   edge with req_valid high and req_stall low. rsp_* returns one transaction
//   per request, in order: the instruction word and an error code; the word
//   is zero whenever the error code is not zero.
//   a request passes the decode, check and pack register stages in order;
//   throughput is one transaction per cycle while rsp_stall is low.
//   reset clears the stage valid bits; rsp_valid is low after reset and any
//   transactions in flight are dropped.
//   when rsp_stall is high the output stage holds its transaction; bubbles
//   in earlier stages still fill, and req_stall rises only once every stage
//   holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alu_instruction_encoder_core_defines.svh"

module alu_instruction_encoder_core import aie_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire logic [4:0]         req_alu_op,
   input  wire logic [7:0]         req_dest_reg,
   input  wire logic               req_src1_present,
   input  wire logic [7:0]         req_src1_reg,
   input  wire logic [7:0]         req_src2_reg,
   input  wire logic               req_mask_enable,
   input  wire logic               req_mask_invert,
   input  wire logic [4:0]         req_mask_reg,
   input  wire logic signed [16:0] req_immediate,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [31:0]             rsp_instruction,
   output logic [2:0]              rsp_error_code
);

   req_type req;
   dec_type dec_data;
   chk_type chk_data;
   logic    dec_valid;
   logic    dec_stall;
   logic    chk_valid;
   logic    chk_stall;
   err_type pack_err;

   always_comb begin
      req.operation    = req_operation;
      req.alu_op       = req_alu_op;
      req.dest_reg     = req_dest_reg;
      req.src1_present = req_src1_present;
      req.src1_reg     = req_src1_reg;
      req.src2_reg     = req_src2_reg;
      req.mask_enable  = req_mask_enable;
      req.mask_invert  = req_mask_invert;
      req.mask_reg     = req_mask_reg;
      req.immediate    = req_immediate;
   end

   aie_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req),
      .in_stall  (req_stall),
      .out_valid (dec_valid),
      .out_data  (dec_data),
      .out_stall (dec_stall)
   );

   aie_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .in_stall  (dec_stall),
      .out_valid (chk_valid),
      .out_data  (chk_data),
      .out_stall (chk_stall)
   );

   aie_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (chk_valid),
      .in_data         (chk_data),
      .in_stall        (chk_stall),
      .out_valid       (rsp_valid),
      .out_instruction (rsp_instruction),
      .out_error       (pack_err),
      .out_stall       (rsp_stall)
   );

   assign rsp_error_code = pack_err;

   // failed encodings never leak a partial word
   `AIE_ASSERT(a_err_zero_word, rsp_valid && (pack_err != ERR_NONE) |-> rsp_instruction == 32'd0, "error response carries a nonzero word")

   // back pressure reaches the request side only with a full pipeline
   `AIE_ASSERT(a_stall_full, req_stall |-> rsp_valid && rsp_stall && dec_valid && chk_valid, "request stalled with a free stage")

   `AIE_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")

endmodule

`default_nettype wire
